### sv/rri_pkg.sv
// ----------------------------------------------------------------------------
// rri_pkg
// Shared types and codes of the ray against rectangle intersection block:
// configuration register indexes, result status codes and channel words.
// ----------------------------------------------------------------------------
`default_nettype none

package rri_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CENTER      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_DIR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_DIR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOL   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PAR_THRESH  = 3'd7;

	typedef enum logic [1:0] {
		ST_INSIDE   = 2'd0,
		ST_OUTSIDE  = 2'd1,
		ST_PARALLEL = 2'd2,
		ST_ZERO     = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [15:0] ray_x;
		logic signed [15:0] ray_y;
		logic signed [15:0] ray_z;
	} ray_word_t;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] hit_x;
		logic signed [15:0] hit_y;
		logic signed [15:0] hit_z;
	} hit_word_t;

endpackage

`default_nettype wire

### sv/rri_stream_if.sv
// ----------------------------------------------------------------------------
// rri_stream_if
// Valid/ready stream channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface rri_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/ray_rectangle_intersection.sv
// ----------------------------------------------------------------------------
// ray_rectangle_intersection
// Normalizes a ray direction, intersects it with the rectangle plane and
// reports whether the hit point lies inside the rectangle, with the point.
// ----------------------------------------------------------------------------
//  channel  dir  word        contents
//  ray      in   ray_word_t  ray_x, ray_y, ray_z direction
//  hit      out  hit_word_t  status, hit_x, hit_y, hit_z (Q8.8)
//  cfg_*    in   plain write register index and data, no read-back
//
//  One ray is accepted every cycle while the last stage is empty or its word
//  is taken. The stages are a 24 stage square root, a DIR_FRAC_BITS + 2 stage
//  divider for the unit vector and a POS_WIDTH stage divider for the hit
//  point, one quotient bit per stage, plus the dot product stages.
//  Reset clears the valid bits and configuration, but sets tol_q/thr_q to 1.
//  When the output word is not taken, the whole pipeline holds in place.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_rectangle_intersection #(
	parameter int POS_WIDTH     = 16,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rri_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rri_pkg::CFG_DATA_W-1:0]  cfg_data,
	rri_stream_if.sink                      ray,
	rri_stream_if.source                    hit
);

	localparam int F    = DIR_FRAC_BITS;
	localparam int PW   = POS_WIDTH;
	localparam int SQN  = 24;
	localparam int RMW  = 27;
	localparam int NUW  = F + 25;
	localparam int UQW  = F + 2;
	localparam int UAW  = 24 + UQW;
	localparam int UW   = F + 3;
	localparam int DNW  = UW + 18;
	localparam int ADW  = F + 18;
	localparam int PRW  = 32 + UQW;
	localparam int NPW  = PRW + 1;
	localparam int PAW  = ADW + PW;
	localparam int EW   = ((PW > 16) ? PW : 16) + 1;
	localparam int EPW  = EW + 16;
	localparam int SW   = EW + 18;
	localparam int CW   = SW + F + 4;
	localparam int NST  = 2 + SQN + 1 + UQW + 6 + PW + 5;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [47:0] center_q, normal_q, ldir_q, wdir_q;
	logic [15:0] rlen_q, rwid_q;
	logic [7:0]  tol_q, thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			normal_q <= '0;
			ldir_q   <= '0;
			wdir_q   <= '0;
			rlen_q   <= '0;
			rwid_q   <= '0;
			tol_q    <= 8'd1;
			thr_q    <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				rri_pkg::REG_CENTER:      center_q <= cfg_data[47:0];
				rri_pkg::REG_NORMAL:      normal_q <= cfg_data[47:0];
				rri_pkg::REG_LENGTH_DIR:  ldir_q   <= cfg_data[47:0];
				rri_pkg::REG_WIDTH_DIR:   wdir_q   <= cfg_data[47:0];
				rri_pkg::REG_RECT_LENGTH: rlen_q   <= cfg_data[15:0];
				rri_pkg::REG_RECT_WIDTH:  rwid_q   <= cfg_data[15:0];
				rri_pkg::REG_PLANE_TOL:   tol_q    <= cfg_data[7:0];
				rri_pkg::REG_PAR_THRESH:  thr_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic signed [15:0] cv [3];
	logic signed [15:0] nv [3];
	logic signed [15:0] lv [3];
	logic signed [15:0] wv [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cv[i] = signed'(center_q[16*i +: 16]);
			nv[i] = signed'(normal_q[16*i +: 16]);
			lv[i] = signed'(ldir_q[16*i +: 16]);
			wv[i] = signed'(wdir_q[16*i +: 16]);
		end
	end

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------
	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		logic [16:0] t;
		t = {v[15], v};
		if (v[15]) t = ~t + 17'd1;
		return t[15:0];
	endfunction

	// Two bits of the radicand {s, 16'b0} consumed by square root stage j.
	function automatic logic [1:0] sqr_pair(input logic [31:0] s, input int j);
		logic [47:0] x;
		x = {s, 16'b0};
		return x[2*(SQN-1-j) +: 2];
	endfunction

	function automatic logic [RMW+23:0] sqrt_step(input logic [RMW-1:0] rem,
			input logic [23:0] root, input logic [1:0] pair);
		logic [RMW-1:0] rem4, trial;
		logic [23:0]    rt;
		rem4  = {rem[RMW-3:0], pair};
		trial = RMW'({root, 2'b01});
		rt    = {root[22:0], 1'b0};
		if (rem4 >= trial) begin
			rem4  = rem4 - trial;
			rt[0] = 1'b1;
		end
		return {rem4, rt};
	endfunction

	// One restoring division step: the accumulator holds the partial
	// remainder on top and the remaining dividend / quotient bits below.
	function automatic logic [UAW-1:0] udiv_step(input logic [UAW-1:0] acc,
			input logic [23:0] d);
		logic [UAW:0] t;
		logic [24:0]  hi;
		t  = {acc, 1'b0};
		hi = t[UAW -: 25];
		if (hi >= {1'b0, d}) begin
			hi   = hi - {1'b0, d};
			t[0] = 1'b1;
		end
		return {hi[23:0], t[UQW-1:0]};
	endfunction

	function automatic logic [PAW-1:0] pdiv_step(input logic [PAW-1:0] acc,
			input logic [ADW-1:0] d);
		logic [PAW:0] t;
		logic [ADW:0] hi;
		t  = {acc, 1'b0};
		hi = t[PAW -: (ADW+1)];
		if (hi >= {1'b0, d}) begin
			hi   = hi - {1'b0, d};
			t[0] = 1'b1;
		end
		return {hi[ADW-1:0], t[PW-1:0]};
	endfunction

	function automatic logic [SW-1:0] abs_sw(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		t = v[SW-1] ? -v : v;
		return unsigned'(t);
	endfunction

	// ------------------------------------------------------------------
	// Flow control: every stage moves together.
	// ------------------------------------------------------------------
	logic [NST-1:0] vld_s;
	logic           adv;

	assign adv       = !vld_s[NST-1] || hit.ready;
	assign ray.ready = adv;
	assign hit.valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], ray.valid};
		end
	end

	// ------------------------------------------------------------------
	// Pipeline registers
	// ------------------------------------------------------------------
	logic signed [15:0] rin [3];
	logic [15:0]        mag_c [3];

	assign rin[0] = ray.data.ray_x;
	assign rin[1] = ray.data.ray_y;
	assign rin[2] = ray.data.ray_z;

	always_comb begin
		for (int i = 0; i < 3; i++) mag_c[i] = abs16(rin[i]);
	end

	logic [2:0][15:0] mag_s1, mag_s2;
	logic [2:0][31:0] sq_s1;
	logic [2:0]       neg_s1, neg_s2;
	logic [31:0]      ssum_s2;
	logic             zero_s2;

	logic [RMW-1:0]   sqr_rem_s  [SQN];
	logic [23:0]      sqr_root_s [SQN];
	logic [31:0]      sqr_val_s  [SQN];
	logic [2:0][15:0] sqr_mag_s  [SQN];
	logic [2:0]       sqr_neg_s  [SQN];
	logic             sqr_zero_s [SQN];

	logic [2:0][NUW-1:0] numu_s3;
	logic [23:0]         m_s3;
	logic [2:0]          neg_s3;
	logic                zero_s3;

	logic [2:0][UAW-1:0] ud_acc_s  [UQW];
	logic [23:0]         ud_d_s    [UQW];
	logic [2:0]          ud_neg_s  [UQW];
	logic                ud_zero_s [UQW];

	logic [2:0][UQW-1:0] umag_s4, umag_s5, umag_s6, umag_s7;
	logic [2:0]          neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic                zero_s4, zero_s5, zero_s6, zero_s7, zero_s8, zero_s9;
	logic signed [UW+15:0] un_s5 [3];
	logic signed [31:0]    cn_s5 [3];
	logic signed [DNW-1:0] dn_s6;
	logic signed [33:0]    cn_s6;
	logic [ADW-1:0]        adn_s7, adn_s8, adn_s9;
	logic [31:0]           acn_s7;
	logic                  par_s7, par_s8, par_s9;
	logic [PRW-1:0]        prod_s8 [3];
	logic [NPW-1:0]        nump_s9 [3];
	logic [2:0]            ov_s9;

	logic [2:0][PAW-1:0] pd_acc_s  [PW];
	logic [ADW-1:0]      pd_d_s    [PW];
	logic [2:0]          pd_ov_s   [PW];
	logic [2:0]          pd_neg_s  [PW];
	logic                pd_zero_s [PW];
	logic                pd_par_s  [PW];

	logic signed [PW-1:0]  p_s10 [3];
	logic signed [PW-1:0]  p_s11 [3];
	logic signed [PW-1:0]  p_s12 [3];
	logic signed [PW-1:0]  p_s13 [3];
	logic signed [EW-1:0]  e_s11 [3];
	logic signed [EPW-1:0] en_s12 [3];
	logic signed [EPW-1:0] el_s12 [3];
	logic signed [EPW-1:0] ew_s12 [3];
	logic signed [SW-1:0]  an_s13, al_s13, aw_s13;
	logic                  zero_s10, zero_s11, zero_s12, zero_s13;
	logic                  par_s10, par_s11, par_s12, par_s13;
	rri_pkg::hit_word_t    out_s14;

	// Combinational values between stages.
	logic signed [UW-1:0]  uval_c [3];
	logic signed [DNW-1:0] dnm_c;
	logic signed [33:0]    cnm_c;
	logic [ADW-1:0]        adn_c;
	logic [NPW-1:0]        nump_c [3];
	logic [PW:0]           qx_c [3];
	logic [PW:0]           lim_c [3];
	logic signed [PW-1:0]  p_c [3];
	logic [CW-1:0]         lhs_n_c, lhs_l_c, lhs_w_c;
	logic                  in_c;
	logic signed [EW-1:0]  pext_c [3];
	rri_pkg::hit_word_t    out_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uval_c[i] = neg_s4[i] ? -signed'({1'b0, umag_s4[i]}) : signed'({1'b0, umag_s4[i]});
		end
		dnm_c = dn_s6[DNW-1] ? -dn_s6 : dn_s6;
		cnm_c = cn_s6[33] ? -cn_s6 : cn_s6;
		adn_c = ADW'(unsigned'(dnm_c));
		for (int i = 0; i < 3; i++) begin
			nump_c[i] = NPW'(prod_s8[i]) + NPW'(adn_s8 >> 1);
		end
		// The hit point magnitude saturates; the negative side reaches one
		// step further than the positive side.
		for (int i = 0; i < 3; i++) begin
			lim_c[i] = ((PW+1)'(1) << (PW - 1)) - (pd_neg_s[PW-1][i] ? '0 : (PW+1)'(1));
			qx_c[i]  = {1'b0, pd_acc_s[PW-1][i][PW-1:0]};
			if (pd_ov_s[PW-1][i] || (qx_c[i] > lim_c[i])) qx_c[i] = lim_c[i];
			if (pd_neg_s[PW-1][i]) qx_c[i] = -qx_c[i];
			p_c[i] = signed'(qx_c[i][PW-1:0]);
		end
		lhs_n_c = CW'(abs_sw(an_s13));
		lhs_l_c = CW'(abs_sw(al_s13)) << 1;
		lhs_w_c = CW'(abs_sw(aw_s13)) << 1;
		in_c = (lhs_n_c <= (CW'(tol_q) << F))
			&& (lhs_l_c < ((CW'(rlen_q) + (CW'(tol_q) << 1)) << F))
			&& (lhs_w_c < ((CW'(rwid_q) + (CW'(tol_q) << 1)) << F));
		for (int i = 0; i < 3; i++) pext_c[i] = EW'(p_s13[i]);
		if (zero_s13) begin
			out_c.status = rri_pkg::ST_ZERO;
		end else if (par_s13) begin
			out_c.status = rri_pkg::ST_PARALLEL;
		end else if (in_c) begin
			out_c.status = rri_pkg::ST_INSIDE;
		end else begin
			out_c.status = rri_pkg::ST_OUTSIDE;
		end
		out_c.hit_x = (zero_s13 || par_s13) ? '0 : signed'(pext_c[0][15:0]);
		out_c.hit_y = (zero_s13 || par_s13) ? '0 : signed'(pext_c[1][15:0]);
		out_c.hit_z = (zero_s13 || par_s13) ? '0 : signed'(pext_c[2][15:0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Magnitudes and squares.
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= rin[i][15];
				sq_s1[i]  <= 32'(mag_c[i]) * 32'(mag_c[i]);
			end
			ssum_s2 <= 32'({2'b0, sq_s1[0]} + {2'b0, sq_s1[1]} + {2'b0, sq_s1[2]});
			zero_s2 <= (mag_s1 == '0);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;

			// Square root of the sum of squares, one root bit per stage.
			{sqr_rem_s[0], sqr_root_s[0]} <= sqrt_step('0, '0, sqr_pair(ssum_s2, 0));
			sqr_val_s[0]  <= ssum_s2;
			sqr_mag_s[0]  <= mag_s2;
			sqr_neg_s[0]  <= neg_s2;
			sqr_zero_s[0] <= zero_s2;
			for (int j = 1; j < SQN; j++) begin
				{sqr_rem_s[j], sqr_root_s[j]} <= sqrt_step(sqr_rem_s[j-1],
					sqr_root_s[j-1], sqr_pair(sqr_val_s[j-1], j));
				sqr_val_s[j]  <= sqr_val_s[j-1];
				sqr_mag_s[j]  <= sqr_mag_s[j-1];
				sqr_neg_s[j]  <= sqr_neg_s[j-1];
				sqr_zero_s[j] <= sqr_zero_s[j-1];
			end

			// Rounded dividends of the unit vector.
			for (int i = 0; i < 3; i++) begin
				numu_s3[i] <= (NUW'(sqr_mag_s[SQN-1][i]) << (F + 8))
					+ NUW'(sqr_root_s[SQN-1][23:1]);
			end
			m_s3    <= sqr_root_s[SQN-1];
			neg_s3  <= sqr_neg_s[SQN-1];
			zero_s3 <= sqr_zero_s[SQN-1];

			// Unit vector divider.
			for (int i = 0; i < 3; i++) ud_acc_s[0][i] <= udiv_step(UAW'(numu_s3[i]), m_s3);
			ud_d_s[0]    <= m_s3;
			ud_neg_s[0]  <= neg_s3;
			ud_zero_s[0] <= zero_s3;
			for (int j = 1; j < UQW; j++) begin
				for (int i = 0; i < 3; i++) begin
					ud_acc_s[j][i] <= udiv_step(ud_acc_s[j-1][i], ud_d_s[j-1]);
				end
				ud_d_s[j]    <= ud_d_s[j-1];
				ud_neg_s[j]  <= ud_neg_s[j-1];
				ud_zero_s[j] <= ud_zero_s[j-1];
			end

			for (int i = 0; i < 3; i++) umag_s4[i] <= ud_acc_s[UQW-1][i][UQW-1:0];
			neg_s4  <= ud_neg_s[UQW-1];
			zero_s4 <= ud_zero_s[UQW-1];

			// Dot products u.n and c.n.
			for (int i = 0; i < 3; i++) begin
				un_s5[i] <= uval_c[i] * nv[i];
				cn_s5[i] <= cv[i] * nv[i];
			end
			umag_s5 <= umag_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;

			dn_s6   <= DNW'(un_s5[0]) + DNW'(un_s5[1]) + DNW'(un_s5[2]);
			cn_s6   <= 34'(cn_s5[0]) + 34'(cn_s5[1]) + 34'(cn_s5[2]);
			umag_s6 <= umag_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;

			adn_s7  <= adn_c;
			acn_s7  <= cnm_c[31:0];
			par_s7  <= (dn_s6 == '0) || (adn_c < (ADW'(thr_q) << F));
			umag_s7 <= umag_s6;
			neg_s7  <= neg_s6;
			zero_s7 <= zero_s6;

			for (int i = 0; i < 3; i++) prod_s8[i] <= PRW'(acn_s7) * PRW'(umag_s7[i]);
			adn_s8  <= adn_s7;
			par_s8  <= par_s7;
			neg_s8  <= neg_s7;
			zero_s8 <= zero_s7;

			for (int i = 0; i < 3; i++) begin
				nump_s9[i] <= nump_c[i];
				ov_s9[i]   <= (nump_c[i] >> PW) >= NPW'(adn_s8);
			end
			adn_s9  <= adn_s8;
			par_s9  <= par_s8;
			neg_s9  <= neg_s8;
			zero_s9 <= zero_s8;

			// Hit point divider.
			for (int i = 0; i < 3; i++) pd_acc_s[0][i] <= pdiv_step(PAW'(nump_s9[i]), adn_s9);
			pd_d_s[0]    <= adn_s9;
			pd_ov_s[0]   <= ov_s9;
			pd_neg_s[0]  <= neg_s9;
			pd_zero_s[0] <= zero_s9;
			pd_par_s[0]  <= par_s9;
			for (int j = 1; j < PW; j++) begin
				for (int i = 0; i < 3; i++) begin
					pd_acc_s[j][i] <= pdiv_step(pd_acc_s[j-1][i], pd_d_s[j-1]);
				end
				pd_d_s[j]    <= pd_d_s[j-1];
				pd_ov_s[j]   <= pd_ov_s[j-1];
				pd_neg_s[j]  <= pd_neg_s[j-1];
				pd_zero_s[j] <= pd_zero_s[j-1];
				pd_par_s[j]  <= pd_par_s[j-1];
			end

			for (int i = 0; i < 3; i++) p_s10[i] <= p_c[i];
			zero_s10 <= pd_zero_s[PW-1];
			par_s10  <= pd_par_s[PW-1];

			for (int i = 0; i < 3; i++) begin
				e_s11[i] <= EW'(p_s10[i]) - EW'(cv[i]);
				p_s11[i] <= p_s10[i];
			end
			zero_s11 <= zero_s10;
			par_s11  <= par_s10;

			for (int i = 0; i < 3; i++) begin
				en_s12[i] <= e_s11[i] * nv[i];
				el_s12[i] <= e_s11[i] * lv[i];
				ew_s12[i] <= e_s11[i] * wv[i];
				p_s12[i]  <= p_s11[i];
			end
			zero_s12 <= zero_s11;
			par_s12  <= par_s11;

			an_s13 <= SW'(en_s12[0]) + SW'(en_s12[1]) + SW'(en_s12[2]);
			al_s13 <= SW'(el_s12[0]) + SW'(el_s12[1]) + SW'(el_s12[2]);
			aw_s13 <= SW'(ew_s12[0]) + SW'(ew_s12[1]) + SW'(ew_s12[2]);
			for (int i = 0; i < 3; i++) p_s13[i] <= p_s12[i];
			zero_s13 <= zero_s12;
			par_s13  <= par_s12;

			out_s14 <= out_c;
		end
	end

	assign hit.data = out_s14;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_miss_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid && (hit.data.status == rri_pkg::ST_ZERO
			|| hit.data.status == rri_pkg::ST_PARALLEL)
		|-> (hit.data.hit_x == 16'sd0 && hit.data.hit_y == 16'sd0
			&& hit.data.hit_z == 16'sd0))
		else $error("zero-length or parallel word carries a nonzero point");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid && !hit.ready |=> $stable(vld_s))
		else $error("pipeline valid bits moved during an output stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && ray.ready |=> vld_s[0])
		else $error("accepted ray word did not enter the first stage");

endmodule

`default_nettype wire
